// ===== hdl/wbps_pkg.sv =====
// Shared types and constants of the wildcard byte pattern scanner.
// Used by the register block, the window cells, the resolve pipeline and the top level.
package wbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int PAT_BYTES   = 16;
  localparam int REL_SIZE    = 4;
  localparam int SPAN_BITS   = $clog2(MAX_PATTERN + REL_SIZE);
  localparam int IDX_W       = (SPAN_BITS > 5) ? SPAN_BITS : 5;
  localparam int ADDR_W      = 6;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_WILD   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_IMAGE_BASE   = 3'd4,
    REG_RESOLVE_MODE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
    logic [63:0] image_base;
    logic        resolve_mode;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [63:0]      start;
    logic [31:0]      disp;
    logic [IDX_W-1:0] wpos;
    logic             use_disp;
  } hit_t;

endpackage

// ===== hdl/wbps_cfg_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on wbps_pkg for the register index codes and the cfg_t bundle.
module wbps_cfg_regs
  import wbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_PATTERN_LOW:  cfg_nxt.pattern_low    = pwdata;
        REG_PATTERN_HIGH: cfg_nxt.pattern_high   = pwdata;
        REG_CARE_MASK:    cfg_nxt.care_mask      = pwdata[15:0];
        REG_PATTERN_LEN:  cfg_nxt.pattern_length = pwdata[4:0];
        REG_IMAGE_BASE:   cfg_nxt.image_base     = pwdata;
        REG_RESOLVE_MODE: cfg_nxt.resolve_mode   = pwdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_LOW:  prdata = cfg_r.pattern_low;
      REG_PATTERN_HIGH: prdata = cfg_r.pattern_high;
      REG_CARE_MASK:    prdata = {48'd0, cfg_r.care_mask};
      REG_PATTERN_LEN:  prdata = {59'd0, cfg_r.pattern_length};
      REG_IMAGE_BASE:   prdata = cfg_r.image_base;
      REG_RESOLVE_MODE: prdata = {63'd0, cfg_r.resolve_mode};
      default:          prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pattern_length: 5'd1, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/wbps_cell.sv =====
// One window cell: holds one image byte, passes it to the next cell on a shift
// and checks the incoming byte against its expected pattern byte. Uses wbps_pkg.
module wbps_cell
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] d_in,
  input  logic [7:0] exp_byte,
  input  logic       exp_care,
  output logic [7:0] q,
  output logic       ok
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign q  = byte_r;
  assign ok = !exp_care || (d_in == exp_byte);

  always_comb begin
    byte_nxt = byte_r;
    if (clear) begin
      byte_nxt = 8'd0;
    end else if (shift) begin
      byte_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// ===== hdl/wbps_resolve.sv =====
// Address pipeline: adds the image base, then, if used, the rel32 displacement,
// into the output register. Depends on wbps_pkg for hit_t and the status codes.
module wbps_resolve
  import wbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hit_valid,
  input  hit_t        hit,
  output logic        hit_ready,
  input  logic [63:0] image_base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_result_address
);

  logic        s2_valid_r;
  logic        s2_valid_nxt;
  status_t     s2_status_r;
  logic [63:0] s2_base_r;
  logic [63:0] s2_offs_r;
  logic        s2_use_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  status_t     out_status_r;
  logic [63:0] out_addr_r;
  logic [63:0] out_addr_nxt;
  logic        out_load;
  logic        s2_adv;
  logic        s2_load;
  logic [63:0] offs_nxt;

  assign out_load  = !out_valid_r || out_ready;
  assign s2_adv    = s2_valid_r && out_load;
  assign s2_load   = !s2_valid_r || s2_adv;
  assign hit_ready = s2_load;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;

  always_comb begin
    offs_nxt = {{32{hit.disp[31]}}, hit.disp} + 64'(hit.wpos) + 64'(REL_SIZE);
  end

  always_comb begin
    if (s2_status_r != ST_FOUND) begin
      out_addr_nxt = 64'd0;
    end else if (s2_use_r) begin
      out_addr_nxt = s2_base_r + s2_offs_r;
    end else begin
      out_addr_nxt = s2_base_r;
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_load) begin
      s2_valid_nxt = hit_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && hit_valid) begin
      s2_status_r <= hit.status;
      s2_base_r   <= image_base + hit.start;
      s2_offs_r   <= offs_nxt;
      s2_use_r    <= hit.use_disp;
    end
    if (s2_adv) begin
      out_status_r <= s2_status_r;
      out_addr_r   <= out_addr_nxt;
    end
  end

endmodule

// ===== hdl/wildcard_byte_pattern_scanner_core.sv =====
// Top level of the wildcard byte pattern scanner: window cell chain, match and
// result control. Depends on wbps_pkg, wbps_cfg_regs, wbps_cell and wbps_resolve.
//
// The scanner takes one image byte per cycle and keeps the newest MAX_PATTERN
// bytes in a chain of cells; every cell compares its incoming byte with the
// pattern byte aligned to it, so the match of the whole window is known in the
// cycle the byte is accepted. At most one result word is given per image: the
// first match, or not found at the last byte; later bytes of the image are
// dropped. A result word passes through the hit register, loaded at the edge that
// accepts the byte that caused it, then the address adder stage, then the output
// register. in_ready stays high as long as the result stages can move, so the
// sustained rate is one byte per cycle; it drops only while results back up behind
// a low out_ready. The user must write configuration only while no byte or result
// is in flight; the block itself does not enforce it.
module wildcard_byte_pattern_scanner_core
  import wbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [63:0]       out_result_address
);

  cfg_t             cfg;
  logic             in_fire;
  logic             shift;
  logic             clear;
  logic [7:0]       win_in   [MAX_PATTERN];
  logic [7:0]       win_q    [MAX_PATTERN];
  logic [7:0]       exp_byte [MAX_PATTERN];
  logic             exp_care [MAX_PATTERN];
  logic             cell_ok  [MAX_PATTERN];
  logic [IDX_W-1:0] len;
  logic [IDX_W-1:0] wpos;
  logic             has_wild;
  logic [IDX_W-1:0] span;
  logic             all_ok;
  logic             match;
  logic [31:0]      disp;
  logic [IDX_W-1:0] didx [REL_SIZE];
  logic [63:0]      offset_r;
  logic [63:0]      offset_nxt;
  logic [63:0]      offset_inc;
  logic             done_r;
  logic             done_nxt;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  hit_t             s1_hit_r;
  hit_t             hit_nxt;
  logic             hit_load;
  logic             hit_ready;

  function automatic logic pat_care(input cfg_t c, input logic [IDX_W-1:0] i);
    logic r;
    r = 1'b0;
    if (i < IDX_W'(PAT_BYTES)) begin
      r = c.care_mask[i[3:0]];
    end
    return r;
  endfunction

  function automatic logic [7:0] pat_byte(input cfg_t c, input logic [IDX_W-1:0] i);
    logic [7:0] r;
    r = 8'd0;
    if (i < IDX_W'(8)) begin
      r = c.pattern_low[{i[2:0], 3'b000} +: 8];
    end else if (i < IDX_W'(PAT_BYTES)) begin
      r = c.pattern_high[{i[2:0], 3'b000} +: 8];
    end
    return r;
  endfunction

  wbps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready   = !s1_valid_r || hit_ready;
  assign in_fire    = in_valid && in_ready;
  assign shift      = in_fire && !done_r;
  assign clear      = in_fire && in_last_byte;
  assign offset_inc = offset_r + 64'd1;

  always_comb begin
    len = IDX_W'(cfg.pattern_length);
    if (len == '0) begin
      len = IDX_W'(1);
    end
    if (len > IDX_W'(MAX_PATTERN)) begin
      len = IDX_W'(MAX_PATTERN);
    end
    has_wild = 1'b0;
    wpos     = '0;
    for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
      if ((IDX_W'(i) < len) && !pat_care(cfg, IDX_W'(i))) begin
        has_wild = 1'b1;
        wpos     = IDX_W'(i);
      end
    end
    span = len;
    if (cfg.resolve_mode && has_wild && (wpos + IDX_W'(REL_SIZE) > len)) begin
      span = wpos + IDX_W'(REL_SIZE);
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [IDX_W-1:0] pidx;

      if (k == 0) begin : g_head
        assign win_in[k] = in_data_byte;
      end else begin : g_link
        assign win_in[k] = win_q[k-1];
      end

      assign pidx        = span - IDX_W'(1) - IDX_W'(k);
      assign exp_care[k] = (IDX_W'(k) < span) && (pidx < len) && pat_care(cfg, pidx);
      assign exp_byte[k] = pat_byte(cfg, pidx);

      wbps_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .clear    (clear),
        .d_in     (win_in[k]),
        .exp_byte (exp_byte[k]),
        .exp_care (exp_care[k]),
        .q        (win_q[k]),
        .ok       (cell_ok[k])
      );
    end
  endgenerate

  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      all_ok = all_ok && cell_ok[i];
    end
    match = all_ok && (span <= IDX_W'(MAX_PATTERN)) && (offset_inc >= 64'(span));
  end

  always_comb begin
    disp = 32'd0;
    for (int j = 0; j < REL_SIZE; j++) begin
      didx[j] = span - IDX_W'(1) - wpos - IDX_W'(j);
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (didx[j] == IDX_W'(i)) begin
          disp[8*j +: 8] = win_in[i];
        end
      end
    end
  end

  always_comb begin
    offset_nxt = offset_r;
    done_nxt   = done_r;
    hit_load   = 1'b0;
    hit_nxt.status   = ST_FOUND;
    hit_nxt.start    = offset_r - 64'(span - IDX_W'(1));
    hit_nxt.disp     = disp;
    hit_nxt.wpos     = wpos;
    hit_nxt.use_disp = cfg.resolve_mode && has_wild;
    if (in_fire && !done_r) begin
      offset_nxt = offset_inc;
      if (match) begin
        hit_load = 1'b1;
        done_nxt = 1'b1;
        if (cfg.resolve_mode && !has_wild) begin
          hit_nxt.status = ST_NO_WILD;
        end
      end else if (in_last_byte) begin
        hit_load       = 1'b1;
        hit_nxt.status = ST_NOT_FOUND;
      end
    end
    if (clear) begin
      offset_nxt = 64'd0;
      done_nxt   = 1'b0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_valid_r && hit_ready) begin
      s1_valid_nxt = 1'b0;
    end
    if (hit_load) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= 64'd0;
      done_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      offset_r   <= offset_nxt;
      done_r     <= done_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_load) begin
      s1_hit_r <= hit_nxt;
    end
  end

  wbps_resolve u_resolve (
    .clk                (clk),
    .rst_n              (rst_n),
    .hit_valid          (s1_valid_r),
    .hit                (s1_hit_r),
    .hit_ready          (hit_ready),
    .image_base         (cfg.image_base),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_result_address (out_result_address)
  );

endmodule
